### rtl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  // Operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_NOT_INIT = 3'd3;
  localparam logic [2:0] ST_BAD_PTR  = 3'd4;
  localparam logic [2:0] ST_ALREADY  = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [16:0] size;
    logic [15:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload_offset;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/first_fit_block_allocator_core.sv
`default_nettype none
// Alloc and free rotate the block table once through the chain of entry cells
// past the head logic. Init steps up one page at a time until the pages cover the
// region; rejected requests go straight to the response state.
// Throughput: one request at a time, busy is high until the result strobe.
// Reset (rst, synchronous): table empty, not initialised, region_size = 65536.
// The result is shown on done for one cycle; the receiver cannot stall it.
module first_fit_block_allocator_core
  import ffa_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 8,
  parameter int PAGE_BYTES   = 4096,
  parameter int REGION_MAX   = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        request,
  output logic             done,
  output rsp_t             result,
  input  wire logic        region_size_wr,
  input  wire logic [16:0] region_size
);

  localparam int SW  = $clog2(REGION_MAX + 1);
  localparam int NW  = ((SW > 18) ? SW : 18) + 1;
  localparam int PW  = ((SW > 16) ? SW : 16) + 1;
  localparam int AW0 = $clog2(REGION_MAX + PAGE_BYTES + 1);
  localparam int RW  = (AW0 > 17) ? AW0 : 17;
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int TW  = $clog2(MAX_BLOCKS + 2);

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_RUN, S_RESP} state_t;

  state_t        state;
  logic [16:0]   region;
  logic [CW-1:0] count;
  logic [CW-1:0] cnt_new;
  logic          initd;
  logic [1:0]    op;
  logic [NW-1:0] need;
  logic [SW-1:0] req_sz;
  logic [15:0]   addr;
  logic [TW-1:0] t;
  logic [SW-1:0] pos;
  logic          found;
  logic          freed;
  logic          merge_next;
  logic [15:0]   off;
  logic [RW-1:0] acc;
  logic [RW-1:0] rsat;
  logic [SW-1:0] qsize [4];
  logic          qbusy [4];
  logic [2:0]    qlen;

  // chain of entry cells
  logic [SW-1:0] c_size [MAX_BLOCKS];
  logic          c_busy [MAX_BLOCKS];
  logic [SW-1:0] emit_size;
  logic          emit_busy;
  logic          init_load;
  logic [SW-1:0] init_size;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
      logic [SW-1:0] nsz;
      logic          nbz;
      if (gi == MAX_BLOCKS - 1) begin : g_tail
        assign nsz = emit_size;
        assign nbz = emit_busy;
      end else begin : g_mid
        assign nsz = c_size[gi+1];
        assign nbz = c_busy[gi+1];
      end
      ffa_cell #(.SW(SW)) u_cell (
        .clk       (clk),
        .shift     (state == S_RUN),
        .load      (init_load && (gi == 0)),
        .load_size (init_size),
        .in_size   (nsz),
        .in_busy   (nbz),
        .out_size  (c_size[gi]),
        .out_busy  (c_busy[gi])
      );
    end
  endgenerate

  // head logic: one table entry per cycle
  logic [SW-1:0] x_size;
  logic          x_busy;
  logic          x_val;
  logic [PW-1:0] poff;
  logic          at_addr;
  logic          fits;
  logic [SW-1:0] nqs [4];
  logic          nqb [4];
  logic [2:0]    nl;
  logic [1:0]    last;
  logic          found_n;
  logic          freed_n;
  logic          mnext_n;
  logic [15:0]   off_n;
  logic [CW-1:0] cnt_n;

  assign x_size  = c_size[0];
  assign x_busy  = c_busy[0];
  assign x_val   = (t < TW'(count));
  assign poff    = PW'(pos) + PW'(HEADER_BYTES);
  assign at_addr = x_val && !found && (poff == PW'(addr));
  assign fits    = x_val && !found && !x_busy && (NW'(x_size) >= need);
  assign rsat    = (RW'(region) > RW'(REGION_MAX)) ? RW'(REGION_MAX) : RW'(region);
  assign init_load = (state == S_INIT) && (acc >= rsat);
  assign init_size = ((acc > RW'(REGION_MAX)) ? SW'(REGION_MAX) : SW'(acc))
                     - SW'(HEADER_BYTES);

  always_comb begin
    nqs = qsize;
    nqb = qbusy;
    nl = qlen;
    found_n = found;
    freed_n = freed;
    mnext_n = merge_next;
    off_n = off;
    cnt_n = cnt_new;
    emit_size = nqs[0];
    emit_busy = nqb[0];
    last = nl[1:0] - 2'd1;
    if (op == OP_ALLOC && fits) begin
      // split: busy block then remainder
      found_n = 1'b1;
      off_n = poff[15:0];
      cnt_n = cnt_new + CW'(1);
      nqs[nl[1:0]] = req_sz;
      nqb[nl[1:0]] = 1'b1;
      nl = nl + 3'd1;
      nqs[nl[1:0]] = SW'(NW'(x_size) - need);
      nqb[nl[1:0]] = 1'b0;
      nl = nl + 3'd1;
    end else if (op == OP_FREE && at_addr) begin
      found_n = 1'b1;
      if (!x_busy) begin
        nqs[nl[1:0]] = x_size;
        nqb[nl[1:0]] = x_busy;
        nl = nl + 3'd1;
      end else begin
        freed_n = 1'b1;
        mnext_n = 1'b1;
        if (qlen != 3'd0 && !qbusy[last]) begin
          nqs[last] = qsize[last] + SW'(HEADER_BYTES) + x_size;
          cnt_n = cnt_new - CW'(1);
        end else begin
          nqs[nl[1:0]] = x_size;
          nqb[nl[1:0]] = 1'b0;
          nl = nl + 3'd1;
        end
      end
    end else if (x_val) begin
      if (merge_next && !x_busy) begin
        // coalesce with the block freed on the previous cycle
        nqs[last] = qsize[last] + SW'(HEADER_BYTES) + x_size;
        cnt_n = cnt_n - CW'(1);
      end else begin
        nqs[nl[1:0]] = x_size;
        nqb[nl[1:0]] = x_busy;
        nl = nl + 3'd1;
      end
      mnext_n = 1'b0;
    end else begin
      mnext_n = 1'b0;
    end
    // emit front entry into the tail cell once the pipeline is primed
    emit_size = nqs[0];
    emit_busy = nqb[0];
    if (t >= TW'(2) && nl != 3'd0) begin
      for (int i = 0; i < 3; i++) begin
        nqs[i] = nqs[i+1];
        nqb[i] = nqb[i+1];
      end
      nl = nl - 3'd1;
    end
  end

  // control and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      region <= 17'd65536;
      count <= '0;
      initd <= 1'b0;
      done <= 1'b0;
      qlen <= '0;
    end else begin
      done <= 1'b0;
      if (region_size_wr) begin
        region <= region_size;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= request.op;
            req_sz <= SW'((NW'(request.size) + NW'(3)) & ~NW'(3));
            need <= ((NW'(request.size) + NW'(3)) & ~NW'(3)) + NW'(HEADER_BYTES);
            addr <= request.address;
            t <= '0;
            pos <= '0;
            found <= 1'b0;
            freed <= 1'b0;
            merge_next <= 1'b0;
            off <= '0;
            qlen <= '0;
            cnt_new <= count;
            acc <= '0;
            result.payload_offset <= '0;
            state <= S_RESP;
            unique case (request.op)
              OP_ALLOC: begin
                if (request.size == 17'd0) result.status <= ST_BAD_SIZE;
                else if (!initd) result.status <= ST_NOT_INIT;
                else if (count >= CW'(MAX_BLOCKS)) result.status <= ST_NO_SPACE;
                else state <= S_RUN;
              end
              OP_FREE: begin
                if (!initd) result.status <= ST_NOT_INIT;
                else state <= S_RUN;
              end
              OP_INIT: begin
                if (initd) result.status <= ST_ALREADY;
                else if (region == 17'd0) result.status <= ST_BAD_SIZE;
                else state <= S_INIT;
              end
              default: result.status <= ST_OK;
            endcase
          end
        end
        S_INIT: begin
          // page rounding by repeated page steps
          if (init_load) begin
            count <= CW'(1);
            initd <= 1'b1;
            result.status <= ST_OK;
            state <= S_RESP;
          end else begin
            acc <= acc + RW'(PAGE_BYTES);
          end
        end
        S_RUN: begin
          qsize <= nqs;
          qbusy <= nqb;
          qlen <= nl;
          found <= found_n;
          freed <= freed_n;
          merge_next <= mnext_n;
          off <= off_n;
          cnt_new <= cnt_n;
          pos <= pos + x_size + SW'(HEADER_BYTES);
          t <= t + TW'(1);
          if (t == TW'(MAX_BLOCKS + 1)) begin
            count <= cnt_n;
            state <= S_RESP;
            if (op == OP_ALLOC) begin
              result.status <= found_n ? ST_OK : ST_NO_SPACE;
              result.payload_offset <= found_n ? off_n : 16'd0;
            end else begin
              result.status <= freed_n ? ST_OK : ST_BAD_PTR;
            end
          end
        end
        S_RESP: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // the rotation drains the head queue completely
  a_q_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> (qlen == 3'd0))
    else $error("head queue not drained at end of pass");

  // block count never exceeds the table
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BLOCKS))
    else $error("block count overflow");

  // a result strobe always follows a busy cycle
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_RESP))
    else $error("result without request");

  // head queue depth bound
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    qlen <= 3'd4)
    else $error("head queue overflow");

endmodule
`default_nettype wire

### rtl/ffa_cell.sv
`default_nettype none
module ffa_cell
  import ffa_pkg::*;
#(
  parameter int SW = 17
) (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire logic          load,
  input  wire logic [SW-1:0] load_size,
  input  wire logic [SW-1:0] in_size,
  input  wire logic          in_busy,
  output logic      [SW-1:0] out_size,
  output logic               out_busy
);

  logic [SW-1:0] size;
  logic          busy;

  // One table entry: direct load at init, else take the neighbor's entry
  always_ff @(posedge clk) begin
    if (load) begin
      size <= load_size;
      busy <= 1'b0;
    end else if (shift) begin
      size <= in_size;
      busy <= in_busy;
    end
  end

  assign out_size = size;
  assign out_busy = busy;

endmodule
`default_nettype wire

### bench/tb_first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
module tb_first_fit_block_allocator_core;
  import ffa_pkg::*;

  localparam int NBLK = 64;
  localparam int HDR = 8;
  localparam int PAGE = 4096;
  localparam int RMAX = 65536;
  localparam int LIMIT = 3000000;
  localparam int DRAIN = 200;

  // Allocator shadow plus queue of expected responses
  class alloc_scoreboard;
    logic [16:0] region;
    int unsigned blk_size[NBLK + 1];
    bit blk_busy[NBLK + 1];
    int unsigned blk_count;
    bit ready;
    rsp_t pending[$];
    int mismatches;
    int checked;

    function new();
      region = 17'd65536;
      blk_count = 0;
      ready = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void remove_entry(int unsigned idx);
      for (int unsigned k = idx; k + 1 < blk_count; k++) begin
        blk_size[k] = blk_size[k + 1];
        blk_busy[k] = blk_busy[k + 1];
      end
      blk_count--;
    endfunction

    // Offsets of currently busy blocks, for picking valid frees
    function int busy_offset(int pick);
      int unsigned pos;
      int n;
      pos = 0;
      n = 0;
      for (int unsigned i = 0; i < blk_count; i++) begin
        if (blk_busy[i]) begin
          if (n == pick) return pos + HDR;
          n++;
        end
        pos += blk_size[i] + HDR;
      end
      return -1;
    endfunction

    function int busy_total();
      int n;
      n = 0;
      for (int unsigned i = 0; i < blk_count; i++) if (blk_busy[i]) n++;
      return n;
    endfunction

    function void note_request(req_t rq);
      logic [2:0] st;
      int unsigned off, r, tot, need, pos, want;
      bit hit;
      st = ST_OK;
      off = 0;
      case (rq.op)
        OP_ALLOC: begin
          if (rq.size == 0) st = ST_BAD_SIZE;
          else if (!ready) st = ST_NOT_INIT;
          else if (blk_count >= NBLK) st = ST_NO_SPACE;
          else begin
            want = (int'(rq.size) + 3) & ~3;
            need = want + HDR;
            pos = 0;
            st = ST_NO_SPACE;
            for (int unsigned i = 0; i < blk_count; i++) begin
              if (!blk_busy[i] && blk_size[i] >= need) begin
                for (int unsigned k = blk_count; k > i + 1; k--) begin
                  blk_size[k] = blk_size[k - 1];
                  blk_busy[k] = blk_busy[k - 1];
                end
                blk_size[i + 1] = blk_size[i] - need;
                blk_busy[i + 1] = 0;
                blk_size[i] = want;
                blk_busy[i] = 1;
                blk_count++;
                off = pos + HDR;
                st = ST_OK;
                break;
              end
              pos += blk_size[i] + HDR;
            end
          end
        end
        OP_FREE: begin
          if (!ready) st = ST_NOT_INIT;
          else begin
            pos = 0;
            hit = 0;
            st = ST_BAD_PTR;
            for (int unsigned i = 0; i < blk_count && !hit; i++) begin
              if (pos + HDR == rq.address) begin
                hit = 1;
                if (blk_busy[i]) begin
                  st = ST_OK;
                  blk_busy[i] = 0;
                  if (i + 1 < blk_count && !blk_busy[i + 1]) begin
                    blk_size[i] += HDR + blk_size[i + 1];
                    remove_entry(i + 1);
                  end
                  if (i > 0 && !blk_busy[i - 1]) begin
                    blk_size[i - 1] += HDR + blk_size[i];
                    remove_entry(i);
                  end
                end
              end
              pos += blk_size[i] + HDR;
            end
          end
        end
        OP_INIT: begin
          r = region;
          if (ready) st = ST_ALREADY;
          else if (r == 0) st = ST_BAD_SIZE;
          else begin
            if (r > RMAX) r = RMAX;
            tot = ((r + PAGE - 1) / PAGE) * PAGE;
            if (tot > RMAX) tot = RMAX;
            blk_size[0] = tot - HDR;
            blk_busy[0] = 0;
            blk_count = 1;
            ready = 1;
          end
        end
        default: ;
      endcase
      if (st != ST_OK) off = 0;
      pending.push_back('{status: st, payload_offset: off[15:0]});
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status=%0d offset=%0d",
                                       got.status, got.payload_offset);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.payload_offset !== exp.payload_offset) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status=%0d offset=%0d, got status=%0d offset=%0d",
                   exp.status, exp.payload_offset, got.status, got.payload_offset);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;
  logic region_size_wr = 0;
  logic [16:0] region_size = 17'd65536;

  alloc_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;

  always #6 clk = ~clk;

  first_fit_block_allocator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .region_size_wr(region_size_wr),
    .region_size(region_size)
  );

  // Response monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Issue one request, honoring the idle percentage
  task automatic send_request(logic [1:0] op, logic [16:0] sz, logic [15:0] addr);
    req_t rq;
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    rq.op = op;
    rq.size = sz;
    rq.address = addr;
    request <= rq;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rq);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_region(logic [16:0] v);
    region_size <= v;
    region_size_wr <= 1'b1;
    @(posedge clk);
    region_size_wr <= 1'b0;
    sb.region = v;
    @(posedge clk);
  endtask

  // Free every busy block, picking the next one at random each time
  task automatic free_all();
    int off;
    while (sb.busy_total() > 0) begin
      off = sb.busy_offset($urandom_range(sb.busy_total() - 1));
      send_request(OP_FREE, 17'($urandom), 16'(off));
    end
  endtask

  // Random request, mostly well formed
  task automatic random_request(int bigmax);
    int sel, n;
    logic [16:0] sz;
    sel = $urandom_range(99);
    if (sel < 50) begin
      if ($urandom_range(19) == 0) sz = 17'($urandom);
      else sz = 17'($urandom_range(bigmax));
      send_request(OP_ALLOC, sz, 16'($urandom));
    end else if (sel < 88) begin
      n = sb.busy_total();
      if (n > 0 && $urandom_range(9) != 0)
        send_request(OP_FREE, 17'($urandom), 16'(sb.busy_offset($urandom_range(n - 1))));
      else
        send_request(OP_FREE, 17'($urandom), 16'($urandom));
    end else if (sel < 94) begin
      send_request(OP_INIT, 17'($urandom), 16'($urandom));
    end else begin
      send_request(OP_NONE, 17'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: use before init, zero region, bad sizes, unused op
    send_request(OP_ALLOC, 17'd0, 16'd0);
    send_request(OP_ALLOC, 17'd5, 16'hFFFF);
    send_request(OP_FREE, 17'h1FFFF, 16'd8);
    send_request(OP_NONE, 17'h1FFFF, 16'hFFFF);
    wait_drained();
    write_region(17'd0);
    send_request(OP_INIT, 17'd0, 16'd0);
    wait_drained();
    write_region(17'h1FFFF);
    send_request(OP_INIT, 17'd0, 16'd0);
    send_request(OP_INIT, 17'd0, 16'd0);
    send_request(OP_ALLOC, 17'd0, 16'd0);
    send_request(OP_ALLOC, 17'h1FFFF, 16'd0);
    send_request(OP_ALLOC, 17'd65536, 16'd0);
    send_request(OP_ALLOC, 17'd1, 16'd0);
    send_request(OP_ALLOC, 17'd65512, 16'd0);
    send_request(OP_FREE, 17'd0, 16'd8);
    send_request(OP_FREE, 17'd0, 16'd8);
    send_request(OP_FREE, 17'd0, 16'd3);
    send_request(OP_FREE, 17'd0, 16'hFFFF);
    // Fill the table to force the full-table case
    for (int i = 0; i < 66; i++) send_request(OP_ALLOC, 17'd4, 16'd0);
    free_all();

    // Random phases; the heap is initialized only via init and stays initialized, so
    // region writes between the phases do not change behavior: a repeated init
    // reports already initialized. Phase 1: sender idles 30%.
    idle_pct = 30;
    for (int i = 0; i < 220; i++) random_request(($urandom_range(3) == 0) ? 65536 : 600);
    // Pressure: hold off until every response is in
    wait_drained();
    write_region(17'd1);
    idle_pct = 85;
    for (int i = 0; i < 220; i++) random_request(($urandom_range(3) == 0) ? 8000 : 300);
    wait_drained();
    write_region(17'($urandom_range(65536, 1)));
    idle_pct = 0;
    for (int i = 0; i < 220; i++) random_request(($urandom_range(3) == 0) ? 65536 : 2000);
    free_all();

    wait_drained();
    $display("Covered %0d responses: alloc, free with coalescing, init, bad size/pointer,",
             sb.checked);
    $display("full table and no-fit cases under three idle profiles.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
